// ----- hw/rtl/hclp_pkg.sv -----
`timescale 1ns / 1ps

package hclp_pkg;

   // Result status codes
   localparam logic [1:0] ST_ABSENT    = 2'd0;
   localparam logic [1:0] ST_VALID     = 2'd1;
   localparam logic [1:0] ST_NO_DIGITS = 2'd2;
   localparam logic [1:0] ST_BAD       = 2'd3;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned KEY_LEN     = 15;

   // Classified header beat, front to back
   typedef struct packed {
      logic [7:0] lc_byte;    // byte with A-Z folded to lower case
      logic       is_nl;
      logic       is_ws;
      logic       is_plus;
      logic       is_minus;
      logic       is_digit;
      logic [3:0] digit;
      logic       is_last;
   } beat_type;

   // "content-length:" in lower case
   function automatic logic [7:0] key_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = 8'h63; // c
         4'd1:    c = 8'h6F; // o
         4'd2:    c = 8'h6E; // n
         4'd3:    c = 8'h74; // t
         4'd4:    c = 8'h65; // e
         4'd5:    c = 8'h6E; // n
         4'd6:    c = 8'h74; // t
         4'd7:    c = 8'h2D; // -
         4'd8:    c = 8'h6C; // l
         4'd9:    c = 8'h65; // e
         4'd10:   c = 8'h6E; // n
         4'd11:   c = 8'h67; // g
         4'd12:   c = 8'h74; // t
         4'd13:   c = 8'h68; // h
         4'd14:   c = 8'h3A; // :
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ----- hw/rtl/hclp_front.sv -----
`timescale 1ns / 1ps

module hclp_front (
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_header_byte,
   input  logic               req_last_byte,
   input  logic               queue_full,
   output logic               push_valid,
   output hclp_pkg::beat_type push_beat
);

   logic [7:0] b;

   assign b          = req_header_byte;
   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full;

   always_comb begin
      push_beat          = '0;
      push_beat.lc_byte  = (b >= 8'h41 && b <= 8'h5A) ? (b + 8'h20) : b;
      push_beat.is_nl    = (b == 8'h0A);
      push_beat.is_ws    = (b == 8'h20) || (b == 8'h09) || (b == 8'h0B) ||
                           (b == 8'h0C) || (b == 8'h0D);
      push_beat.is_plus  = (b == 8'h2B);
      push_beat.is_minus = (b == 8'h2D);
      push_beat.is_digit = (b >= 8'h30) && (b <= 8'h39);
      push_beat.digit    = push_beat.is_digit ? 4'(b - 8'h30) : 4'd0;
      push_beat.is_last  = req_last_byte;
   end

endmodule

// ----- hw/rtl/hclp_queue.sv -----
`timescale 1ns / 1ps

module hclp_queue #(
   parameter int unsigned DEPTH = hclp_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  hclp_pkg::beat_type push_beat,
   output logic               full,
   output logic               pop_valid,
   input  logic               pop,
   output hclp_pkg::beat_type pop_beat
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   hclp_pkg::beat_type data_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_beat  = data_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_beat;
      end
   end

endmodule

// ----- hw/rtl/hclp_back.sv -----
`timescale 1ns / 1ps

module hclp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  hclp_pkg::beat_type pop_beat,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [30:0]        rsp_body_length,
   output logic [1:0]         rsp_length_status
);

   typedef enum logic [2:0] {
      PH_PREFIX   = 3'd0,
      PH_SKIPWS   = 3'd1,
      PH_SIGN_POS = 3'd2,
      PH_SIGN_NEG = 3'd3,
      PH_DIG_POS  = 3'd4,
      PH_DIG_NEG  = 3'd5,
      PH_SKIPLINE = 3'd6
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  matched;
      logic [30:0] value;
      logic [1:0]  status;
      logic        decided;
   } ctx_type;

   localparam ctx_type CTX_RESET = '{
      phase:   PH_PREFIX,
      matched: 4'd0,
      value:   31'd0,
      status:  hclp_pkg::ST_ABSENT,
      decided: 1'b0
   };

   ctx_type     ctx_ff, ctx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [30:0] body_length_ff, body_length_in;
   logic [1:0]  status_ff, status_in;

   // Judge the matching line when it ends
   function automatic ctx_type end_line(input ctx_type c);
      ctx_type r;
      r = c;
      if (!c.decided) begin
         unique case (c.phase)
            PH_SKIPWS, PH_SIGN_POS, PH_SIGN_NEG: begin
               r.status  = hclp_pkg::ST_NO_DIGITS;
               r.decided = 1'b1;
            end
            PH_DIG_POS: begin
               r.status  = hclp_pkg::ST_VALID;
               r.decided = 1'b1;
            end
            PH_DIG_NEG: begin
               r.value   = '0;
               r.status  = hclp_pkg::ST_VALID;
               r.decided = 1'b1;
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   // Positive digit step: value*10 + digit, flag overflow past 2^31-1
   function automatic ctx_type pos_digit(input ctx_type c, input hclp_pkg::beat_type bt);
      ctx_type     r;
      logic [34:0] prod;
      r    = c;
      prod = {c.value, 3'b000} + {3'b000, c.value, 1'b0} + {31'd0, bt.digit};
      if (!bt.is_digit) begin
         r = end_line(c);
      end else if (prod[34:31] != 4'd0) begin
         r.value   = '0;
         r.status  = hclp_pkg::ST_BAD;
         r.decided = 1'b1;
      end else begin
         r.value = prod[30:0];
         r.phase = PH_DIG_POS;
      end
      return r;
   endfunction

   assign pop = pop_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      ctx_type c;
      c              = ctx_ff;
      ctx_in         = ctx_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      body_length_in = body_length_ff;
      status_in      = status_ff;
      if (pop) begin
         if (!c.decided) begin
            if (pop_beat.is_nl) begin
               c         = end_line(c);
               c.phase   = PH_PREFIX;
               c.matched = '0;
               c.value   = '0;
            end else begin
               unique case (c.phase)
                  PH_PREFIX: begin
                     if (c.matched != 4'(hclp_pkg::KEY_LEN) &&
                         pop_beat.lc_byte == hclp_pkg::key_char(c.matched)) begin
                        c.matched = c.matched + 4'd1;
                        if (c.matched == 4'(hclp_pkg::KEY_LEN)) begin
                           c.phase = PH_SKIPWS;
                        end
                     end else begin
                        c.phase = PH_SKIPLINE;
                     end
                  end
                  PH_SKIPWS: begin
                     if (pop_beat.is_ws) begin
                        c = c;
                     end else if (pop_beat.is_plus) begin
                        c.phase = PH_SIGN_POS;
                     end else if (pop_beat.is_minus) begin
                        c.phase = PH_SIGN_NEG;
                     end else begin
                        c = pos_digit(c, pop_beat);
                     end
                  end
                  PH_SIGN_POS, PH_DIG_POS: begin
                     c = pos_digit(c, pop_beat);
                  end
                  PH_SIGN_NEG, PH_DIG_NEG: begin
                     if (!pop_beat.is_digit) begin
                        c = end_line(c);
                     end else if (pop_beat.digit != 4'd0) begin
                        c.value   = '0;
                        c.status  = hclp_pkg::ST_BAD;
                        c.decided = 1'b1;
                     end else begin
                        c.phase = PH_DIG_NEG;
                     end
                  end
                  default: ;
               endcase
            end
         end
         if (pop_beat.is_last) begin
            c              = end_line(c);
            rsp_valid_in   = 1'b1;
            body_length_in = (c.decided && c.status == hclp_pkg::ST_VALID) ? c.value : '0;
            status_in      = c.decided ? c.status : hclp_pkg::ST_ABSENT;
            ctx_in         = CTX_RESET;
         end else begin
            ctx_in = c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff       <= CTX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctx_ff         <= ctx_in;
         rsp_valid_ff   <= rsp_valid_in;
         body_length_ff <= body_length_in;
         status_ff      <= status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_body_length   = body_length_ff;
   assign rsp_length_status = status_ff;

endmodule

// ----- hw/rtl/http_content_length_parser_unit.sv -----
`timescale 1ns / 1ps

// Channel | Dir | Ports                                      | Beat
// req     | in  | req_valid, req_stall, req_header_byte,     | one header byte,
//         |     | req_last_byte                              | last flag
// rsp     | out | rsp_valid, rsp_stall, rsp_body_length,     | one result per
//         |     | rsp_length_status                          | header block
//
// One byte per cycle while the queue has room; the back end pops one beat per
// cycle unless a held result stalls it, and finishes its state update for that
// beat in the same cycle. A last byte goes via the queue into the result register.
// Reset (synchronous) empties the queue and returns the parser to line start.
// rsp_stall holds the result register; bytes keep entering until the queue
// of QUEUE_DEPTH beats fills, then req_stall rises.

module http_content_length_parser_unit #(
   parameter int unsigned QUEUE_DEPTH = hclp_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_header_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [30:0] rsp_body_length,
   output logic [1:0]  rsp_length_status
);

   logic               queue_full;
   logic               push_valid;
   hclp_pkg::beat_type push_beat;
   logic               pop_valid;
   logic               pop;
   hclp_pkg::beat_type pop_beat;

   // Front: handshake and byte classification (case fold, digit, blank, sign, newline)
   hclp_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_header_byte (req_header_byte),
      .req_last_byte   (req_last_byte),
      .queue_full      (queue_full),
      .push_valid      (push_valid),
      .push_beat       (push_beat)
   );

   // Short beat queue decouples input acceptance from result back-pressure
   hclp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_beat  (push_beat),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_beat   (pop_beat)
   );

   // Back: line/prefix tracking, value accumulation, result register
   hclp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_beat          (pop_beat),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_body_length   (rsp_body_length),
      .rsp_length_status (rsp_length_status)
   );

endmodule

// ----- verif/tb_http_content_length_parser_unit.sv -----
`timescale 1ns / 1ps

// Testbench for the Content-Length header parser.
// Header blocks (directed first, then random) are queued as byte beats.
// A clocked driver presents them with random gaps. A clocked monitor takes
// results with random stalls. A scanner model, updated on every accepted
// byte, predicts the result of each block and stores it for the monitor.

module tb_http_content_length_parser_unit;

   localparam string       KEY_TEXT       = "content-length:";
   localparam string       BLANK_TEXT     = " \t\013\014\r";
   localparam logic [7:0]  NEWLINE        = 8'h0A;
   localparam logic [63:0] LENGTH_MAX     = 64'd2147483647;
   localparam int          MIN_BYTES      = 1600;
   localparam int          MIN_BLOCKS     = 60;
   localparam int          DRAIN_EVERY    = 25;   // random blocks from one drain pause to the next
   localparam int          WATCHDOG_LIMIT = 2000;

   // Scanner position within the current line
   typedef enum logic [2:0] {
      AT_KEY,        // comparing against the header name
      IN_BLANKS,     // skipping blanks after the colon
      AFTER_PLUS,
      AFTER_MINUS,
      IN_DIGITS,     // positive number under way
      IN_ZEROS,      // negative sign followed only by zeros so far
      REST_OF_LINE   // line does not count
   } scan_phase_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
      bit         drain;   // hold this beat until every result has come back
      int         gap;     // idle cycles after this beat
   } header_beat_type;

   typedef struct packed {
      logic [30:0] body_length;
      logic [1:0]  status;
   } length_result_type;

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [7:0]  req_header_byte = 8'h00;
   logic        req_last_byte   = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [30:0] rsp_body_length;
   logic [1:0]  rsp_length_status;

   http_content_length_parser_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_header_byte   (req_header_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_body_length   (rsp_body_length),
      .rsp_length_status (rsp_length_status)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   header_beat_type   pending_beats[$];
   length_result_type expected_lengths[$];
   logic [7:0]        block_bytes[$];      // block being assembled

   // Scanner state
   scan_phase_type scan_phase  = AT_KEY;
   int unsigned    key_pos     = 0;
   logic [30:0]    length_acc  = '0;
   logic [1:0]     verdict     = hclp_pkg::ST_ABSENT;
   bit             verdict_set = 1'b0;

   // Bookkeeping
   int errors         = 0;
   int bytes_planned  = 0;
   int blocks_planned = 0;
   int random_blocks  = 0;
   int bytes_accepted = 0;
   int blocks_done    = 0;
   int status_count[4];
   bit calm_sender    = 1'b0;
   bit calm_receiver  = 1'b0;
   int hold_cycles    = 0;
   int stall_left     = 0;
   int stall_draw;
   int idle_cycles    = 0;
   header_beat_type   next_beat;
   length_result_type oldest;

   // ---------------------------------------------------------------------
   // Scanner model
   // ---------------------------------------------------------------------

   function automatic bit is_blank(logic [7:0] b);
      return b == 8'h20 || b == 8'h09 || b == 8'h0B || b == 8'h0C || b == 8'h0D;
   endfunction

   function automatic void set_verdict(logic [1:0] s);
      verdict     = s;
      verdict_set = 1'b1;
   endfunction

   // A line ends (newline or end of block): judge it if it was the key line.
   function automatic void close_line();
      if (verdict_set)
         return;
      case (scan_phase)
         IN_BLANKS, AFTER_PLUS, AFTER_MINUS: set_verdict(hclp_pkg::ST_NO_DIGITS);
         IN_DIGITS: set_verdict(hclp_pkg::ST_VALID);
         IN_ZEROS: begin
            length_acc = '0;   // minus zero is plain zero
            set_verdict(hclp_pkg::ST_VALID);
         end
         default: ;
      endcase
   endfunction

   function automatic void clear_scanner();
      scan_phase  = AT_KEY;
      key_pos     = 0;
      length_acc  = '0;
      verdict     = hclp_pkg::ST_ABSENT;
      verdict_set = 1'b0;
   endfunction

   function automatic void scan_header_byte(logic [7:0] b);
      logic [7:0]  folded;
      logic [63:0] grown;
      bit          digit;
      bit          numeric;
      digit   = b >= 8'h30 && b <= 8'h39;
      numeric = 1'b0;
      // once judged, the rest of the block is ignored
      if (verdict_set)
         return;
      if (b == NEWLINE) begin
         close_line();
         scan_phase = AT_KEY;
         key_pos    = 0;
         length_acc = '0;
         return;
      end
      case (scan_phase)
         AT_KEY: begin
            folded = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
            if (key_pos < hclp_pkg::KEY_LEN && folded == KEY_TEXT[key_pos]) begin
               key_pos++;
               if (key_pos == hclp_pkg::KEY_LEN)
                  scan_phase = IN_BLANKS;
            end else begin
               scan_phase = REST_OF_LINE;
            end
         end
         IN_BLANKS: begin
            if (is_blank(b))
               ;
            else if (b == 8'h2B)
               scan_phase = AFTER_PLUS;
            else if (b == 8'h2D)
               scan_phase = AFTER_MINUS;
            else
               numeric = 1'b1;   // first non-blank may already be a digit
         end
         AFTER_PLUS, IN_DIGITS: numeric = 1'b1;
         AFTER_MINUS, IN_ZEROS: begin
            if (!digit) begin
               close_line();
            end else if (b != 8'h30) begin
               length_acc = '0;
               set_verdict(hclp_pkg::ST_BAD);
            end else begin
               scan_phase = IN_ZEROS;
            end
         end
         default: ;
      endcase
      if (numeric) begin
         if (!digit) begin
            close_line();
         end else begin
            grown = {33'd0, length_acc} * 64'd10 + {56'd0, b} - 64'h30;
            if (grown > LENGTH_MAX) begin
               length_acc = '0;
               set_verdict(hclp_pkg::ST_BAD);
            end else begin
               length_acc = grown[30:0];
               scan_phase = IN_DIGITS;
            end
         end
      end
   endfunction

   // One accepted beat: advance the scanner, and on the last byte of a
   // block store the expected result and start over.
   function automatic void track_length_byte(logic [7:0] b, logic last);
      length_result_type r;
      scan_header_byte(b);
      if (last) begin
         close_line();
         r.body_length = (verdict_set && verdict == hclp_pkg::ST_VALID) ? length_acc : '0;
         r.status      = verdict_set ? verdict : hclp_pkg::ST_ABSENT;
         expected_lengths.insert(expected_lengths.size(), r);
         status_count[r.status]++;
         blocks_done++;
         clear_scanner();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------

   function automatic void add_byte(logic [7:0] b);
      block_bytes.insert(block_bytes.size(), b);
   endfunction

   function automatic void append_text(string s);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i]);
   endfunction

   // Header name with a random mix of letter case, first n characters only
   function automatic void append_key(int n);
      logic [7:0] c;
      for (int i = 0; i < n; i++) begin
         c = KEY_TEXT[i];
         if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1)
            c = c - 8'h20;
         add_byte(c);
      end
   endfunction

   function automatic void append_length_line();
      longint unsigned near_max;
      int              n;
      append_key(hclp_pkg::KEY_LEN);
      n = $urandom_range(0, 3);
      repeat (n) add_byte(BLANK_TEXT[$urandom_range(0, 4)]);
      case ($urandom_range(0, 9))
         0, 1: add_byte(8'h2B);
         2, 3: add_byte(8'h2D);
         default: ;
      endcase
      case ($urandom_range(0, 5))
         0: append_text($sformatf("%0d", $urandom_range(0, 9999)));
         1: begin
            // straddle the overflow boundary
            near_max = 64'd2147483627 + $urandom_range(0, 40);
            append_text($sformatf("%0d", near_max));
         end
         2: begin
            n = $urandom_range(1, 12);
            repeat (n) add_byte(8'h30 + 8'($urandom_range(0, 9)));
         end
         3: begin
            n = $urandom_range(1, 3);
            repeat (n) add_byte(8'h30);
         end
         4: ;   // no digits at all
         default: append_text($sformatf("0%0d", $urandom_range(1, 999)));
      endcase
      case ($urandom_range(0, 3))
         0: add_byte(8'($urandom_range(0, 255)));
         1: add_byte(8'h0D);
         default: ;
      endcase
   endfunction

   function automatic void append_random_block();
      int n_lines;
      int n;
      n_lines = $urandom_range(0, 3);
      for (int i = 0; i < n_lines; i++) begin
         case ($urandom_range(0, 9))
            6, 7: begin
               n = $urandom_range(1, 8);
               repeat (n) add_byte(8'($urandom_range(0, 255)));
            end
            8: begin
               // header name cut short, then anything
               append_key($urandom_range(1, hclp_pkg::KEY_LEN - 1));
               add_byte(8'($urandom_range(0, 255)));
            end
            9: ;   // empty line
            default: append_length_line();
         endcase
         // final line may end with the block instead of a newline
         if (i < n_lines - 1 || $urandom_range(0, 1) == 1)
            add_byte(NEWLINE);
      end
      if (block_bytes.size() == 0)
         add_byte(8'($urandom_range(0, 255)));
   endfunction

   // Move the assembled block into the send queue, last flag on its final byte
   function automatic void commit_block(bit drain);
      header_beat_type beat;
      foreach (block_bytes[i]) begin
         beat.data  = block_bytes[i];
         beat.last  = (i == block_bytes.size() - 1);
         beat.drain = drain && i == 0;
         beat.gap   = calm_sender ? 0 : $urandom_range(0, 4);
         pending_beats.insert(pending_beats.size(), beat);
      end
      bytes_planned += block_bytes.size();
      blocks_planned++;
      block_bytes.delete();
   endfunction

   // ---------------------------------------------------------------------
   // Driver: presents queued beats, holds payload while stalled, and idles
   // for each beat's gap once it has been taken.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         hold_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            track_length_byte(req_header_byte, req_last_byte);
            bytes_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (hold_cycles > 0) begin
               hold_cycles <= hold_cycles - 1;
               req_valid   <= 1'b0;
            end else if (pending_beats.size() > 0 &&
                         !(pending_beats[0].drain && expected_lengths.size() > 0)) begin
               next_beat = pending_beats.pop_front();
               req_valid       <= 1'b1;
               req_header_byte <= next_beat.data;
               req_last_byte   <= next_beat.last;
               hold_cycles     <= next_beat.gap;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each result beat against the oldest expectation, then
   // draws a stall stretch; calm stretches have no stall.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_lengths.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, body_length %0d status %0d", $time,
                        rsp_body_length, rsp_length_status);
            end else begin
               oldest = expected_lengths.pop_front();
               if (rsp_body_length !== oldest.body_length) begin
                  errors++;
                  $display("%0t: body_length expected %0d, actual %0d", $time,
                           oldest.body_length, rsp_body_length);
               end
               if (rsp_length_status !== oldest.status) begin
                  errors++;
                  $display("%0t: length_status expected %0d, actual %0d", $time,
                           oldest.status, rsp_length_status);
               end
            end
            if ($urandom_range(0, 9) == 0)
               calm_receiver = !calm_receiver;
            stall_draw = calm_receiver ? 0 : $urandom_range(0, 4);
            rsp_stall  <= stall_draw > 0;
            stall_left <= stall_draw > 0 ? stall_draw - 1 : 0;
         end else if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: too long without any beat on either side ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("tb_http_content_length_parser_unit: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: build stimulus, release reset, wait for drain, report.
   // ---------------------------------------------------------------------
   initial begin
      foreach (status_count[i]) status_count[i] = 0;

      // directed blocks
      append_text("X");                                    // no header at all
      commit_block(1'b0);
      append_text("content-length: 0\n");                  // last byte is a newline
      commit_block(1'b0);
      append_text("CONTENT-LENGTH:\t+2147483647");         // largest value, ends mid-line
      commit_block(1'b0);
      append_text("Content-Length:2147483648\n");          // one past the largest
      commit_block(1'b0);
      append_text("content-length: -000\r\n");             // minus zero
      commit_block(1'b0);
      append_text("content-length:-7\n");                  // negative nonzero
      commit_block(1'b0);
      append_text("content-length: \r\n");                 // no digits
      commit_block(1'b0);
      append_text("content-length:5\ncontent-length:9\n"); // first match wins
      commit_block(1'b0);
      append_text("x: 1\ncOnTeNt-LeNgTh:12ab");            // digits stop at a letter
      commit_block(1'b0);

      // random blocks, with a full drain pause now and then
      while (bytes_planned < MIN_BYTES || blocks_planned < MIN_BLOCKS) begin
         if ($urandom_range(0, 7) == 0)
            calm_sender = !calm_sender;
         append_random_block();
         commit_block(random_blocks % DRAIN_EVERY == 0);
         random_blocks++;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // sample away from the active edge so driver updates have settled
      while (pending_beats.size() > 0 || req_valid) @(negedge clock);
      while (expected_lengths.size() > 0) @(negedge clock);
      repeat (8) @(negedge clock);   // room for a stray late result

      $display("Ran %0d header blocks, %0d bytes, idling and stalls on both sides.",
               blocks_done, bytes_accepted);
      $display("Status mix: absent %0d, valid %0d, no digits %0d, bad %0d.",
               status_count[hclp_pkg::ST_ABSENT], status_count[hclp_pkg::ST_VALID],
               status_count[hclp_pkg::ST_NO_DIGITS], status_count[hclp_pkg::ST_BAD]);
      if (errors == 0) begin
         $display("tb_http_content_length_parser_unit: PASS");
      end else begin
         $display("tb_http_content_length_parser_unit: FAIL");
      end
      $finish;
   end

endmodule
